// ===== rtl/sorted_key_value_table_core_defines.svh =====
// Assertion macros shared by the checker of the sorted key/value table.
`ifndef SORTED_KEY_VALUE_TABLE_CORE_DEFINES_SVH
`define SORTED_KEY_VALUE_TABLE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SKVT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SKVT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/skvt_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted key/value table package
// Beat types, operation and status codes, and controller/datapath interfaces.
// ----------------------------------------------------------------------------
package skvt_pkg;

    // Default sizes of the table.
    localparam int CAPACITY_DEF    = 256;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int KEY_WIDTH       = 32;

    // Operation codes.
    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_CHANGE = 2'd2;
    localparam logic [1:0] CMD_ERASE  = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_EXISTS    = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // Request beat.
    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] key;
        logic [31:0]        value_in;
    } t_in_beat;

    // Result beat.
    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [31:0] value_out;
        logic [8:0]  entry_count;
    } t_out_beat;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic shift_up;
        logic shift_down;
        logic shift;
        logic write_entry;
        logic write_value;
        logic finish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] op;
        logic       scan_done;
        logic       found;
        logic       full;
        logic       shift_done;
        logic       out_full;
    } t_dp_status;

endpackage

// ===== rtl/skvt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module skvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/skvt_datapath.sv =====
// ----------------------------------------------------------------------------
// Sorted key/value table datapath
// Key and value memories, scan compare, entry shifting and the result register.
// ----------------------------------------------------------------------------
module skvt_datapath #(
    parameter int CAPACITY    = skvt_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = skvt_pkg::VALUE_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  skvt_pkg::t_dp_cmd     i_cmd,
    output skvt_pkg::t_dp_status  o_status,
    input  skvt_pkg::t_in_beat    i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output skvt_pkg::t_out_beat   o_out_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = skvt_pkg::KEY_WIDTH;

    // Request registers.
    logic [1:0]             r_cmd,  n_cmd;
    logic [KW-1:0]          r_key,  n_key;
    logic [VALUE_WIDTH-1:0] r_val,  n_val;
    // Table state.
    logic [CW-1:0]          r_count, n_count;
    // Walk state for the scan and the shift; the count left and direction serve the shift only.
    logic [CW-1:0]          r_rd_idx, n_rd_idx;
    logic                   r_pend, n_pend;
    logic [AW-1:0]          r_pend_idx, n_pend_idx;
    logic [CW-1:0]          r_left, n_left;
    logic                   r_up, n_up;
    // Scan outcome.
    logic                   r_found, n_found;
    logic [CW-1:0]          r_pos, n_pos;
    logic [VALUE_WIDTH-1:0] r_vout, n_vout;
    // Result register.
    logic                   r_out_valid, n_out_valid;
    skvt_pkg::t_out_beat    r_out_data, n_out_data;

    // Memory ports.
    logic                   key_we, val_we;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    logic [KW-1:0]          key_wdata, key_rdata;
    logic [VALUE_WIDTH-1:0] val_wdata, val_rdata;

    logic                   key_eq, key_ge, scan_done, shift_done, full;
    logic [AW-1:0]          shift_waddr;
    skvt_pkg::t_out_beat    res;
    logic [CW-1:0]          res_count;

    skvt_ram #(.WIDTH(KW), .DEPTH(CAPACITY)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (ram_waddr),
        .i_wdata (key_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (key_rdata)
    );

    skvt_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (ram_waddr),
        .i_wdata (val_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (val_rdata)
    );

    // Compare the key read last cycle with the requested key.
    assign key_eq      = r_pend && (key_rdata == r_key);
    assign key_ge      = r_pend && ($signed(key_rdata) >= $signed(r_key));
    assign scan_done   = key_ge || (!r_pend && (r_rd_idx >= r_count));
    assign shift_done  = (r_left == '0) && !r_pend;
    assign full        = r_count >= CW'(CAPACITY);
    assign shift_waddr = r_up ? r_pend_idx + AW'(1) : r_pend_idx - AW'(1);
    assign ram_raddr   = r_rd_idx[AW-1:0];

    // Memory write selection.
    always_comb begin
        key_we    = 1'b0;
        val_we    = 1'b0;
        ram_waddr = r_pos[AW-1:0];
        key_wdata = r_key;
        val_wdata = r_val;
        if (i_cmd.shift && r_pend) begin
            key_we    = 1'b1;
            val_we    = 1'b1;
            ram_waddr = shift_waddr;
            key_wdata = key_rdata;
            val_wdata = val_rdata;
        end else if (i_cmd.write_entry) begin
            key_we = 1'b1;
            val_we = 1'b1;
        end else if (i_cmd.write_value) begin
            val_we = 1'b1;
        end
    end

    // Result of the request from the scan outcome.
    always_comb begin
        res           = '0;
        res_count     = r_count;
        res.found     = r_found;
        unique case (r_cmd)
            skvt_pkg::CMD_LOOKUP: begin
                if (r_found) begin
                    res.status    = skvt_pkg::ST_OK;
                    res.value_out = 32'(r_vout);
                end else begin
                    res.status = skvt_pkg::ST_NOT_FOUND;
                end
            end
            skvt_pkg::CMD_INSERT: begin
                if (r_found) begin
                    res.status = skvt_pkg::ST_EXISTS;
                end else if (full) begin
                    res.status = skvt_pkg::ST_FULL;
                end else begin
                    res.status = skvt_pkg::ST_OK;
                    res_count  = r_count + CW'(1);
                end
            end
            skvt_pkg::CMD_CHANGE: begin
                res.status = r_found ? skvt_pkg::ST_OK : skvt_pkg::ST_NOT_FOUND;
            end
            skvt_pkg::CMD_ERASE: begin
                if (r_found) begin
                    res.status = skvt_pkg::ST_OK;
                    res_count  = r_count - CW'(1);
                end else begin
                    res.status = skvt_pkg::ST_NOT_FOUND;
                end
            end
        endcase
        res.entry_count = 9'(res_count);
    end

    // Next-state logic for the datapath registers.
    always_comb begin
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_val       = r_val;
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        n_pend      = r_pend;
        n_pend_idx  = r_pend_idx;
        n_left      = r_left;
        n_up        = r_up;
        n_found     = r_found;
        n_pos       = r_pos;
        n_vout      = r_vout;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cmd.load) begin
            // Capture the request and start the scan at the first entry.
            n_cmd    = i_in_data.cmd;
            n_key    = i_in_data.key;
            n_val    = VALUE_WIDTH'(i_in_data.value_in);
            n_rd_idx = '0;
            n_pend   = 1'b0;
        end else if (i_cmd.scan) begin
            // Stop at the first entry whose key is not below the request key.
            if (scan_done) begin
                n_found = key_eq;
                n_pos   = r_pend ? CW'(r_pend_idx) : r_count;
                n_vout  = val_rdata;
                n_pend  = 1'b0;
            end else if (r_rd_idx < r_count) begin
                n_pend     = 1'b1;
                n_pend_idx = r_rd_idx[AW-1:0];
                n_rd_idx   = r_rd_idx + CW'(1);
            end else begin
                n_pend = 1'b0;
            end
        end else if (i_cmd.shift_up) begin
            // Move entries from the top down to the insert slot one place up.
            n_up     = 1'b1;
            n_rd_idx = r_count - CW'(1);
            n_left   = r_count - r_pos;
            n_pend   = 1'b0;
        end else if (i_cmd.shift_down) begin
            // Move entries above the erased one one place down.
            n_up     = 1'b0;
            n_rd_idx = r_pos + CW'(1);
            n_left   = r_count - r_pos - CW'(1);
            n_pend   = 1'b0;
        end else if (i_cmd.shift) begin
            // Read one entry per cycle; it is written back on the next cycle.
            if (r_left != '0) begin
                n_pend     = 1'b1;
                n_pend_idx = r_rd_idx[AW-1:0];
                n_rd_idx   = r_up ? r_rd_idx - CW'(1) : r_rd_idx + CW'(1);
                n_left     = r_left - CW'(1);
            end else begin
                n_pend = 1'b0;
            end
        end else if (i_cmd.finish) begin
            n_count     = res_count;
            n_out_data  = res;
            n_out_valid = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and walk registers.
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_key      <= n_key;
        r_val      <= n_val;
        r_rd_idx   <= n_rd_idx;
        r_pend_idx <= n_pend_idx;
        r_left     <= n_left;
        r_up       <= n_up;
        r_found    <= n_found;
        r_pos      <= n_pos;
        r_vout     <= n_vout;
        r_out_data <= n_out_data;
    end

    // Status toward the controller.
    always_comb begin
        o_status            = '0;
        o_status.op         = r_cmd;
        o_status.scan_done  = scan_done;
        o_status.found      = r_found;
        o_status.full       = full;
        o_status.shift_done = shift_done;
        o_status.out_full   = r_out_valid && !i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== rtl/skvt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sorted key/value table controller
// Sequences scan, shift and write steps of one request and hands off results.
// ----------------------------------------------------------------------------
module skvt_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  skvt_pkg::t_dp_status  i_status,
    output skvt_pkg::t_dp_cmd     o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_PLAN   = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_WRITE  = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0] r_state, n_state;

    // State transitions and datapath commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_done) begin
                    n_state = S_PLAN;
                end
            end
            S_PLAN: begin
                n_state = S_FINISH;
                unique case (i_status.op)
                    skvt_pkg::CMD_LOOKUP: begin
                        n_state = S_FINISH;
                    end
                    skvt_pkg::CMD_INSERT: begin
                        if (!i_status.found && !i_status.full) begin
                            o_cmd.shift_up = 1'b1;
                            n_state        = S_SHIFT;
                        end
                    end
                    skvt_pkg::CMD_CHANGE: begin
                        o_cmd.write_value = i_status.found;
                    end
                    skvt_pkg::CMD_ERASE: begin
                        if (i_status.found) begin
                            o_cmd.shift_down = 1'b1;
                            n_state          = S_SHIFT;
                        end
                    end
                endcase
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_status.shift_done) begin
                    n_state = (i_status.op == skvt_pkg::CMD_INSERT) ? S_WRITE : S_FINISH;
                end
            end
            S_WRITE: begin
                o_cmd.write_entry = 1'b1;
                n_state           = S_FINISH;
            end
            S_FINISH: begin
                // Wait until the result register is free.
                if (!i_status.out_full) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/sorted_key_value_table_core.sv =====
// ----------------------------------------------------------------------------
// Sorted key/value table core
// Fixed-capacity table of key/value pairs kept in ascending signed key order.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Beat
//  request   in         i_in_valid / o_in_ready   cmd, key, value_in
//  result    out        o_out_valid / i_out_ready status, found, value_out, entry_count
//
//  A request scans the stored entries, one read per cycle, up to the first key
//  not below the request key. A decision step follows; an insert then shifts
//  the entries from its slot upward up and writes the new entry, an erase
//  shifts those above its slot down, and a hand-off step offers the result.
//  Reset clears the entry count, the pending read, the result valid flag and
//  the controller state. A request is taken while the previous result waits;
//  the hand-off then stalls until the result register is free.
// ----------------------------------------------------------------------------
module sorted_key_value_table_core #(
    parameter int CAPACITY    = skvt_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = skvt_pkg::VALUE_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  skvt_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output skvt_pkg::t_out_beat o_out_data
);

    skvt_pkg::t_dp_cmd    dp_cmd;
    skvt_pkg::t_dp_status dp_status;

    skvt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    skvt_datapath #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== rtl/skvt_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted key/value table checker
// Port-level assertions, bound to the core.
// ----------------------------------------------------------------------------
`include "sorted_key_value_table_core_defines.svh"

module skvt_checker #(
    parameter int CAPACITY = skvt_pkg::CAPACITY_DEF
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input skvt_pkg::t_in_beat  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input skvt_pkg::t_out_beat o_out_data
);

    // A stalled result beat stays offered.
    `SKVT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "result beat dropped while stalled")

    // Only one request is worked on at a time.
    `SKVT_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "request taken while another is in progress")

    // A full refusal reports an absent key and a full table.
    `SKVT_ASSERT_NOW(a_full_count, i_clk, i_rst_n, o_out_valid && (o_out_data.status == skvt_pkg::ST_FULL), !o_out_data.found && (o_out_data.entry_count == 9'(CAPACITY)), "full status with wrong count or found flag")

    // A nonzero value only comes from a successful lookup hit.
    `SKVT_ASSERT_NOW(a_value_on_hit, i_clk, i_rst_n, o_out_valid && (o_out_data.value_out != 32'd0), o_out_data.found && (o_out_data.status == skvt_pkg::ST_OK), "value returned without a hit")

endmodule

bind sorted_key_value_table_core skvt_checker #(.CAPACITY(CAPACITY)) u_skvt_checker (.*);
